### sv/vts_pkg.sv
// ----------------------------------------------------------------------------
// Version tag scanner package
// Shared types and character constants for the version tag scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package vts_pkg;

  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // A part value after one more digit: at most 65535 * 10 + 9, so 20 bits.
  localparam int unsigned ACC_EXT_W = 20;

  localparam logic [ACC_EXT_W-1:0] MAJOR_MAX = ACC_EXT_W'(255);
  localparam logic [ACC_EXT_W-1:0] MINOR_MAX = ACC_EXT_W'(255);
  localparam logic [ACC_EXT_W-1:0] PATCH_MAX = ACC_EXT_W'(65535);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_V     = 3'd1,
    PH_MAJOR = 3'd2,
    PH_DOT1  = 3'd3,
    PH_MINOR = 3'd4,
    PH_DOT2  = 3'd5,
    PH_PATCH = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [31:0] best;
    logic        found;
  } scan_state_t;

  typedef struct packed {
    logic        found;
    logic [31:0] best;
  } scan_result_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    phase: PH_IDLE,
    acc:   16'd0,
    major: 8'd0,
    minor: 8'd0,
    best:  32'd0,
    found: 1'b0
  };

endpackage

`default_nettype wire

### sv/vts_scan_step.sv
// ----------------------------------------------------------------------------
// Version tag scanner step
// Next scan state and end-of-image result for one image byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_scan_step (
  input  vts_pkg::scan_state_t  state,
  input  logic [7:0]            byte_value,
  input  logic                  last_byte,
  output vts_pkg::scan_state_t  state_next,
  output vts_pkg::scan_result_t result
);
  import vts_pkg::*;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ACC_EXT_W-1:0] acc_grown;
  logic [ACC_EXT_W-1:0] limit;
  logic                 commit;
  logic [31:0]          candidate;
  scan_state_t          n;

  assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign digit     = is_digit ? 4'(byte_value - CH_ZERO) : 4'd0;
  assign acc_ext   = ACC_EXT_W'(state.acc);
  assign acc_grown = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(digit);

  always_comb begin
    unique case (state.phase)
      PH_MAJOR: limit = MAJOR_MAX;
      PH_MINOR: limit = MINOR_MAX;
      default:  limit = PATCH_MAX;
    endcase
  end

  always_comb begin
    n         = state;
    n.phase   = PH_IDLE;
    commit    = 1'b0;
    candidate = 32'd0;

    unique case (state.phase)
      PH_V: begin
        if (is_digit) begin
          n.acc   = 16'(digit);
          n.phase = PH_MAJOR;
        end
      end
      PH_DOT1: begin
        if (is_digit) begin
          n.acc   = 16'(digit);
          n.phase = PH_MINOR;
        end
      end
      PH_DOT2: begin
        if (is_digit) begin
          n.acc   = 16'(digit);
          n.phase = PH_PATCH;
        end
      end
      PH_MAJOR, PH_MINOR, PH_PATCH: begin
        if (is_digit) begin
          // An overflowing digit drops the tag and is consumed.
          if (acc_grown <= limit) begin
            n.acc   = acc_grown[15:0];
            n.phase = state.phase;
          end
        end else if (state.phase == PH_PATCH) begin
          commit = 1'b1;
        end else if (byte_value == CH_DOT) begin
          if (state.phase == PH_MAJOR) begin
            n.major = state.acc[7:0];
            n.phase = PH_DOT1;
          end else begin
            n.minor = state.acc[7:0];
            n.phase = PH_DOT2;
          end
        end
      end
      default: begin
      end
    endcase

    if (!is_digit && byte_value == CH_V) begin
      n.phase = PH_V;
    end

    // A patch still running at the end of the image completes there.
    if (last_byte && n.phase == PH_PATCH) begin
      commit = 1'b1;
    end

    candidate = {n.major, n.minor, n.acc};
    if (commit && (!state.found || candidate > state.best)) begin
      n.best  = candidate;
      n.found = 1'b1;
    end

    result.found = n.found;
    result.best  = n.found ? n.best : 32'd0;

    state_next = last_byte ? SCAN_STATE_RESET : n;
  end

endmodule

`default_nettype wire

### sv/version_tag_scanner_core.sv
// ----------------------------------------------------------------------------
// Version tag scanner core
// Streams image bytes and reports the largest vMAJOR.MINOR.PATCH tag.
// ----------------------------------------------------------------------------
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | byte_value[7:0], last_byte
//   out     | out_valid / out_ready| tag_found, best_version[31:0]
//
// One byte per cycle while in_ready is high: a byte is registered, then
// updates the scan state through one digit multiply-add and a 32-bit
// compare. The result of the last byte is held in the result register.
// in_ready drops only while a registered last byte waits for a full,
// stalled result register. Reset (rst, synchronous) empties both registers
// and clears the scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module version_tag_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tag_found,
  output logic [31:0] best_version
);
  import vts_pkg::*;

  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         stage_last;
  logic         advance;
  scan_state_t  state;
  scan_state_t  state_next;
  scan_result_t result;

  assign advance  = stage_valid && (!stage_last || !out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  vts_scan_step u_step (
    .state      (state),
    .byte_value (stage_byte),
    .last_byte  (stage_last),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= byte_value;
      stage_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      tag_found    <= result.found;
      best_version <= result.best;
    end
  end

  // The end of an image leaves the scanner in its reset state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_last) |=> (state.phase == PH_IDLE && !state.found && state.best == 32'd0))
    else $error("scan state not cleared after last byte");

  // A report without a tag carries no version.
  a_no_tag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tag_found) |-> (best_version == 32'd0))
    else $error("version reported without a tag");

  // Input stalls only behind a last byte blocked by a pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && stage_last && out_valid && !out_ready))
    else $error("input stalled without cause");

  // The stored best never falls while a tag is held.
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    ($past(state.found) && state.found && !$past(rst)) |-> (state.best >= $past(state.best)))
    else $error("best version decreased");

  // The unused phase code is never reached.
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    state.phase != 3'd7)
    else $error("illegal scan phase");

endmodule

`default_nettype wire
